>>> hdl/pth_pkg.sv
// shared types and constants of the proth primality test block
// no dependencies; used by pth_addsub and proth_primality_test
package pth_pkg;

   // fixed field widths of the request beat
   localparam int K_W  = 32;
   localparam int N_W  = 10;
   localparam int A_W  = 16;
   // candidate bit length kb + n, at most 32 + 1023
   localparam int S_W  = 11;
   // bit length of k and index into k
   localparam int KB_W = 6;
   localparam int KI_W = 5;
   // word size that bounds the width of every reduced value
   localparam int WORD_BITS = 32;
   localparam int WORD_SH   = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PSHIFT,
      ST_MU,
      ST_AMOD,
      ST_NEXT,
      ST_MUL,
      ST_QEST,
      ST_QP,
      ST_WSUB,
      ST_FIX,
      ST_FINISH
   } state_type;

   // operation of the shared adder
   typedef struct packed {
      logic sub;
      logic use_b;
   } au_op_type;

endpackage

>>> hdl/pth_addsub.sv
// shared wide adder / subtractor with carry out
// depends on pth_pkg for the operation struct
module pth_addsub #(
   parameter int UW = 2049
) (
   input  pth_pkg::au_op_type op,
   input  logic [UW-1:0]      a,
   input  logic [UW-1:0]      b,
   output logic [UW:0]        res
);

   logic [UW-1:0] b_gated;
   logic [UW-1:0] b_eff;

   // gate and invert the second operand; carry out high means a >= b on subtract
   always_comb begin
      b_gated = op.use_b ? b : '0;
      b_eff   = op.sub ? ~b_gated : b_gated;
      res     = {1'b0, a} + {1'b0, b_eff} + {{UW{1'b0}}, op.sub};
   end

endmodule

>>> hdl/proth_primality_test.sv
// proth primality test: p = k*2^n+1, verdict a^((p-1)/2) mod p == p-1
// candidate length s = kb + n, sd = ceil(s/32) words; m modular products (at most 2*kb + n - 3),
// each one bit-serial multiply, estimate and q*p pass
// one beat at a time, taken only in idle; a zero k, zero n or oversized candidate goes straight to the verdict
// synchronous active-high reset clears the sequencer and the response valid
// depends on pth_pkg and pth_addsub
module proth_primality_test #(
   parameter int P_BITS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [pth_pkg::K_W-1:0]  req_k_multiplier,
   input  logic [pth_pkg::N_W-1:0]  req_exponent_n,
   input  logic [pth_pkg::A_W-1:0]  req_base_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_is_prime,
   output logic                     rsp_status
);

   localparam int PW   = P_BITS;
   localparam int DIG  = (P_BITS + 31) / 32;
   localparam int XW   = 32 * DIG;
   localparam int DW   = 2 * XW;
   localparam int UW   = DW + 1;
   localparam int CW   = $clog2(DW + 2);
   localparam int SDW  = $clog2(DIG + 1);

   pth_pkg::state_type state_ff, state_in;

   logic [pth_pkg::K_W-1:0]  k_ff, k_in;
   logic [pth_pkg::N_W-1:0]  n_ff, n_in;
   logic [pth_pkg::A_W-1:0]  a_ff, a_in;
   logic [pth_pkg::S_W-1:0]  s_ff, s_in;
   logic [SDW-1:0]           sd_ff, sd_in;
   logic [PW-1:0]            p_ff, p_in;
   logic [PW:0]              mu_ff, mu_in;
   logic [PW-1:0]            rem_ff, rem_in;
   logic [pth_pkg::A_W-1:0]  dsrc_ff, dsrc_in;
   logic [XW-1:0]            base_ff, base_in;
   logic [XW-1:0]            r_ff, r_in;
   logic [DW-1:0]            w_ff, w_in;
   logic [DW-1:0]            acc_ff, acc_in;
   logic [DW-1:0]            mcand_ff, mcand_in;
   logic [DW-1:0]            mplier_ff, mplier_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            lim_ff, lim_in;
   logic [pth_pkg::KI_W-1:0] kidx_ff, kidx_in;
   logic [pth_pkg::N_W-1:0]  sq_ff, sq_in;
   logic                     mpend_ff, mpend_in;
   logic                     fin_prime_ff, fin_prime_in;
   logic                     fin_status_ff, fin_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_prime_ff, rsp_prime_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic [pth_pkg::KB_W-1:0] kb_c;
   logic [pth_pkg::S_W-1:0]  s_c;
   logic                     big_c;
   logic [PW:0]              t_c;
   logic [XW-1:0]            mask_c;
   logic [XW-1:0]            pm1_c;
   logic                     cnt_done;
   logic                     shr_c;
   logic                     ge_c;
   logic [CW-1:0]            mul_lim_c;

   pth_pkg::au_op_type au_op;
   logic [UW-1:0]      au_a;
   logic [UW-1:0]      au_b;
   logic [UW:0]        au_res;

   pth_addsub #(.UW(UW)) u_addsub (
      .op  (au_op),
      .a   (au_a),
      .b   (au_b),
      .res (au_res)
   );

   // bit length of k, candidate length and helper values
   always_comb begin
      kb_c = '0;
      for (int j = 0; j < pth_pkg::K_W; j++) begin
         if (k_ff[j]) kb_c = pth_pkg::KB_W'(j + 1);
      end
      s_c       = pth_pkg::S_W'(kb_c) + pth_pkg::S_W'(n_ff);
      big_c     = (32'(s_c) > P_BITS);
      t_c       = {rem_ff, dsrc_ff[pth_pkg::A_W-1]};
      pm1_c     = XW'({p_ff[PW-1:1], 1'b0});
      cnt_done  = (cnt_ff == lim_ff);
      shr_c     = (cnt_ff < CW'({s_ff, 1'b0}));
      ge_c      = au_res[UW];
      mul_lim_c = CW'(sd_ff) << pth_pkg::WORD_SH;
      for (int j = 0; j < XW; j++) begin
         mask_c[j] = (32'(j) < (32'(sd_ff) << pth_pkg::WORD_SH));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pth_pkg::ST_IDLE: begin
            if (req_valid) state_in = pth_pkg::ST_CHECK;
         end
         pth_pkg::ST_CHECK: begin
            if (k_ff == '0 || n_ff == '0 || big_c) state_in = pth_pkg::ST_FINISH;
            else state_in = pth_pkg::ST_PSHIFT;
         end
         pth_pkg::ST_PSHIFT: begin
            if (cnt_done) state_in = pth_pkg::ST_MU;
         end
         pth_pkg::ST_MU: begin
            if (cnt_done) begin
               if (sd_ff == SDW'(1)) state_in = pth_pkg::ST_AMOD;
               else state_in = pth_pkg::ST_NEXT;
            end
         end
         pth_pkg::ST_AMOD: begin
            if (cnt_done) state_in = pth_pkg::ST_NEXT;
         end
         pth_pkg::ST_NEXT: begin
            if (mpend_ff || kidx_ff != '0 || sq_ff != '0) state_in = pth_pkg::ST_MUL;
            else state_in = pth_pkg::ST_FINISH;
         end
         pth_pkg::ST_MUL: begin
            if (cnt_done) state_in = pth_pkg::ST_QEST;
         end
         pth_pkg::ST_QEST: begin
            if (cnt_done) state_in = pth_pkg::ST_QP;
         end
         pth_pkg::ST_QP: begin
            if (cnt_done) state_in = pth_pkg::ST_WSUB;
         end
         pth_pkg::ST_WSUB: state_in = pth_pkg::ST_FIX;
         pth_pkg::ST_FIX: state_in = pth_pkg::ST_NEXT;
         pth_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = pth_pkg::ST_IDLE;
         end
         default: state_in = pth_pkg::ST_IDLE;
      endcase
   end

   // shared adder operand select
   always_comb begin
      au_op = '0;
      au_a  = '0;
      au_b  = '0;
      unique case (state_ff)
         pth_pkg::ST_MU, pth_pkg::ST_AMOD: begin
            au_op.sub   = 1'b1;
            au_op.use_b = 1'b1;
            au_a        = UW'(t_c);
            au_b        = UW'(p_ff);
         end
         pth_pkg::ST_MUL, pth_pkg::ST_QEST, pth_pkg::ST_QP: begin
            au_op.use_b = mplier_ff[0];
            au_a        = UW'(acc_ff);
            au_b        = UW'(mcand_ff);
         end
         pth_pkg::ST_WSUB: begin
            au_op.sub   = 1'b1;
            au_op.use_b = 1'b1;
            au_a        = UW'(w_ff);
            au_b        = UW'(acc_ff);
         end
         pth_pkg::ST_FIX: begin
            au_op.sub   = 1'b1;
            au_op.use_b = 1'b1;
            au_a        = UW'(w_ff);
            au_b        = UW'(p_ff);
         end
         default: begin
            au_op = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      k_in = k_ff;  n_in = n_ff;  a_in = a_ff;
      s_in = s_ff;  sd_in = sd_ff;  p_in = p_ff;  mu_in = mu_ff;
      rem_in = rem_ff;  dsrc_in = dsrc_ff;  base_in = base_ff;  r_in = r_ff;
      w_in = w_ff;  acc_in = acc_ff;  mcand_in = mcand_ff;  mplier_in = mplier_ff;
      cnt_in = cnt_ff;  lim_in = lim_ff;  kidx_in = kidx_ff;  sq_in = sq_ff;
      mpend_in = mpend_ff;  fin_prime_in = fin_prime_ff;  fin_status_in = fin_status_ff;

      // response register, free to take a new verdict once drained
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_prime_in  = rsp_prime_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         pth_pkg::ST_IDLE: begin
            if (req_valid) begin
               k_in = req_k_multiplier;
               n_in = req_exponent_n;
               a_in = req_base_value;
            end
         end
         // candidate size, special cases and loop counters
         pth_pkg::ST_CHECK: begin
            s_in          = s_c;
            sd_in         = SDW'((s_c + pth_pkg::S_W'(31)) >> pth_pkg::WORD_SH);
            p_in          = PW'(k_ff);
            cnt_in        = '0;
            lim_in        = CW'(n_ff);
            kidx_in       = pth_pkg::KI_W'(kb_c - pth_pkg::KB_W'(1));
            sq_in         = n_ff - pth_pkg::N_W'(1);
            mpend_in      = 1'b0;
            fin_prime_in  = 1'b0;
            fin_status_in = (k_ff != '0) && (n_ff != '0) && big_c;
         end
         // shift k up by n, then set the low bit
         pth_pkg::ST_PSHIFT: begin
            if (cnt_done) begin
               p_in    = p_ff | PW'(1);
               rem_in  = '0;
               mu_in   = '0;
               dsrc_in = {1'b1, {(pth_pkg::A_W-1){1'b0}}};
               cnt_in  = '0;
               lim_in  = CW'({s_ff, 1'b1});
            end else begin
               p_in   = p_ff << 1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // restoring division of 2^(2s) by p
         pth_pkg::ST_MU: begin
            if (cnt_done) begin
               rem_in  = '0;
               dsrc_in = a_ff;
               cnt_in  = '0;
               lim_in  = CW'(pth_pkg::A_W);
               base_in = XW'(a_ff);
               r_in    = XW'(a_ff);
            end else begin
               rem_in  = ge_c ? au_res[PW-1:0] : t_c[PW-1:0];
               mu_in   = {mu_ff[PW-1:0], ge_c};
               dsrc_in = dsrc_ff << 1;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         // base modulo a one-word candidate
         pth_pkg::ST_AMOD: begin
            if (cnt_done) begin
               base_in = XW'(rem_ff);
               r_in    = XW'(rem_ff);
            end else begin
               rem_in  = ge_c ? au_res[PW-1:0] : t_c[PW-1:0];
               dsrc_in = dsrc_ff << 1;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         // exponent sequencer: multiply by base, square for a bit of k, final squarings, or the verdict
         pth_pkg::ST_NEXT: begin
            acc_in   = '0;
            mcand_in = DW'(r_ff);
            cnt_in   = '0;
            lim_in   = mul_lim_c;
            if (mpend_ff) begin
               mplier_in = DW'(base_ff);
               mpend_in  = 1'b0;
            end else if (kidx_ff != '0) begin
               mplier_in = DW'(r_ff);
               kidx_in   = kidx_ff - pth_pkg::KI_W'(1);
               mpend_in  = k_ff[kidx_ff - pth_pkg::KI_W'(1)];
            end else if (sq_ff != '0) begin
               mplier_in = DW'(r_ff);
               sq_in     = sq_ff - pth_pkg::N_W'(1);
            end else begin
               fin_prime_in  = (r_ff == pm1_c);
               fin_status_in = 1'b0;
            end
         end
         // product w = x * y
         pth_pkg::ST_MUL: begin
            if (cnt_done) begin
               w_in      = acc_ff;
               mplier_in = acc_ff;
               mcand_in  = DW'(mu_ff);
               acc_in    = '0;
               cnt_in    = '0;
               lim_in    = CW'(sd_ff) << (pth_pkg::WORD_SH + 1);
            end else begin
               acc_in    = au_res[DW-1:0];
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         // quotient estimate q = floor(w * mu / 2^(2s)), low 2s bits shifted out
         pth_pkg::ST_QEST: begin
            if (cnt_done) begin
               mplier_in = acc_ff;
               mcand_in  = DW'(p_ff);
               acc_in    = '0;
               cnt_in    = '0;
               lim_in    = mul_lim_c + CW'(pth_pkg::WORD_BITS);
            end else begin
               if (shr_c) begin
                  acc_in = au_res[DW:1];
               end else begin
                  acc_in   = au_res[DW-1:0];
                  mcand_in = mcand_ff << 1;
               end
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         // q * p
         pth_pkg::ST_QP: begin
            if (!cnt_done) begin
               acc_in    = au_res[DW-1:0];
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         pth_pkg::ST_WSUB: begin
            w_in = au_res[DW-1:0];
         end
         // one conditional subtract, keep sd words
         pth_pkg::ST_FIX: begin
            r_in = (ge_c ? au_res[XW-1:0] : w_ff[XW-1:0]) & mask_c;
         end
         pth_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_prime_in  = fin_prime_ff;
               rsp_status_in = fin_status_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pth_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      n_ff          <= n_in;
      a_ff          <= a_in;
      s_ff          <= s_in;
      sd_ff         <= sd_in;
      p_ff          <= p_in;
      mu_ff         <= mu_in;
      rem_ff        <= rem_in;
      dsrc_ff       <= dsrc_in;
      base_ff       <= base_in;
      r_ff          <= r_in;
      w_ff          <= w_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      cnt_ff        <= cnt_in;
      lim_ff        <= lim_in;
      kidx_ff       <= kidx_in;
      sq_ff         <= sq_in;
      mpend_ff      <= mpend_in;
      fin_prime_ff  <= fin_prime_in;
      fin_status_ff <= fin_status_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready    = (state_ff == pth_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   // an accepted request beat starts the size check
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == pth_pkg::ST_CHECK))
      else $error("accepted beat did not start the size check");

   // the quotient estimate never overshoots: q * p <= w
   a_q_under: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pth_pkg::ST_WSUB) |-> au_res[UW])
      else $error("barrett quotient estimate too large");

   // division remainder stays below p
   a_rem_lt_p: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pth_pkg::ST_MU || state_ff == pth_pkg::ST_AMOD) |-> (rem_ff < p_ff))
      else $error("division remainder out of range");

   // oversized candidate never reports prime
   a_status_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_is_prime))
      else $error("prime verdict with oversize status");
`endif

endmodule

>>> dv/proth_primality_test_test.sv
// testbench of the proth primality test block: directed and random candidates
// checked against a bit-accurate barrett-reduction predictor; needs pth_pkg and the rtl
`timescale 1ns / 1ps

module proth_primality_test_test;

   localparam int PBITS      = 1024;
   localparam int IDLE_LIMIT = 300000;

   typedef logic [511:0] wide_type;

   typedef struct {
      logic [pth_pkg::K_W-1:0] k;
      logic [pth_pkg::N_W-1:0] n;
      logic [pth_pkg::A_W-1:0] a;
   } cand_type;

   typedef struct {
      logic is_prime;
      logic status;
   } verdict_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [pth_pkg::K_W-1:0] req_k_multiplier;
   logic [pth_pkg::N_W-1:0] req_exponent_n;
   logic [pth_pkg::A_W-1:0] req_base_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_is_prime;
   logic                    rsp_status;

   cand_type    pending_cands[$];
   verdict_type expected_verdicts[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          errors;
   int          quiet_cycles;
   logic        req_taken;

   proth_primality_test #(.P_BITS(PBITS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_k_multiplier(req_k_multiplier), .req_exponent_n(req_exponent_n),
      .req_base_value(req_base_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_is_prime(rsp_is_prime), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // keep the low bits words of v
   function automatic wide_type keep_words(wide_type v, int words);
      wide_type one;
      one = 1;
      return v & ((one << (32 * words)) - 1);
   endfunction

   // x*y mod p the way the datapath does it: barrett estimate, one fix-up subtract
   function automatic wide_type barrett_mulmod(wide_type x, wide_type y, wide_type p,
                                               wide_type mu, int s, int sd);
      wide_type w, prod, q, z;
      w    = keep_words(x, sd) * keep_words(y, sd);
      prod = w * keep_words(mu, sd + 1);
      q    = keep_words(prod >> (2 * s), sd + 1);
      z    = q * p;
      w    = keep_words(w - z, 2 * sd + 1);
      if (w >= p)
         w = keep_words(w - p, 2 * sd + 1);
      return keep_words(w, sd);
   endfunction

   // proth witness a^((p-1)/2) mod p == p-1 for p = k*2^n+1
   function automatic verdict_type proth_verdict(cand_type c);
      verdict_type v;
      wide_type    p, mu, base, acc, one;
      int          kb, s, sd;
      v.is_prime = 1'b0;
      v.status   = 1'b0;
      one        = 1;
      if (c.k == 0 || c.n == 0)
         return v;
      kb = 0;
      for (int i = 0; i < pth_pkg::K_W; i++)
         if (c.k[i]) kb = i + 1;
      s = kb + int'(c.n);
      if (s > PBITS) begin
         v.status = 1'b1;
         return v;
      end
      sd   = (s + 31) / 32;
      p    = (wide_type'(c.k) << c.n) | one;
      mu   = (one << (2 * s)) / p;
      base = (sd == 1) ? wide_type'(c.a) % p : wide_type'(c.a);
      acc  = base;
      for (int i = kb - 2; i >= 0; i--) begin
         acc = barrett_mulmod(acc, acc, p, mu, s, sd);
         if (c.k[i]) acc = barrett_mulmod(acc, base, p, mu, s, sd);
      end
      for (int i = 1; i < int'(c.n); i++)
         acc = barrett_mulmod(acc, acc, p, mu, s, sd);
      v.is_prime = (keep_words(acc, sd) == p - one);
      return v;
   endfunction

   // driver: new beat at the falling edge once the previous one is gone
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_cands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cand_type c;
            c = pending_cands.pop_front();
            req_k_multiplier <= c.k;
            req_exponent_n   <= c.n;
            req_base_value   <= c.a;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // request side: predict each accepted beat
   always @(posedge clock) begin
      cand_type c;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         c.k = req_k_multiplier;
         c.n = req_exponent_n;
         c.a = req_base_value;
         expected_verdicts.push_back(proth_verdict(c));
      end
   end

   // response side: compare with the oldest prediction
   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            e = expected_verdicts.pop_front();
            if (rsp_is_prime !== e.is_prime) begin
               $error("is_prime: expected %0d actual %0d", e.is_prime, rsp_is_prime);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAIL proth_primality_test");
         $finish;
      end
   end

   task automatic add_cand(logic [pth_pkg::K_W-1:0] k, logic [pth_pkg::N_W-1:0] n,
                           logic [pth_pkg::A_W-1:0] a);
      cand_type c;
      c.k = k;
      c.n = n;
      c.a = a;
      pending_cands.push_back(c);
   endtask

   // mostly candidates up to 32 bits, some up to 64, a few degenerate or oversized
   task automatic add_random_cand();
      int pick, kb, n;
      logic [pth_pkg::K_W-1:0] k;
      pick = $urandom_range(99);
      if (pick < 5) begin
         add_cand('0, pth_pkg::N_W'($urandom_range(1023)), pth_pkg::A_W'($urandom));
      end else if (pick < 10) begin
         add_cand($urandom, '0, pth_pkg::A_W'($urandom));
      end else if (pick < 16) begin
         add_cand($urandom | 32'h8000_0000, pth_pkg::N_W'($urandom_range(1023, 993)),
                  pth_pkg::A_W'($urandom));
      end else if (pick < 26) begin
         kb = $urandom_range(32, 1);
         n  = $urandom_range(64 - kb, (kb < 32) ? 33 - kb : 1);
         k  = pth_pkg::K_W'((64'($urandom) | 64'h1) & ((64'h1 << kb) - 64'h1));
         k[kb-1] = 1'b1;
         add_cand(k, pth_pkg::N_W'(n), pth_pkg::A_W'($urandom));
      end else begin
         kb = $urandom_range(31, 1);
         n  = $urandom_range(32 - kb, 1);
         k  = $urandom & ((32'h1 << kb) - 1);
         k[kb-1] = 1'b1;
         if ($urandom_range(3) != 0) k[0] = 1'b1;
         add_cand(k, pth_pkg::N_W'(n), pth_pkg::A_W'($urandom));
      end
   endtask

   task automatic drain();
      wait (pending_cands.size() == 0 && !req_valid && expected_verdicts.size() == 0);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_k_multiplier = '0;
      req_exponent_n   = '0;
      req_base_value   = '0;
      rsp_ready        = 1'b0;
      req_taken        = 1'b0;
      errors           = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: small primes, degenerate inputs, extremes of every field
      add_cand(1, 1, 2);                     // p = 3
      add_cand(1, 2, 3);                     // p = 5
      add_cand(3, 2, 2);                     // p = 13
      add_cand(3, 5, 5);                     // p = 97
      add_cand(1, 8, 3);                     // p = 257
      add_cand(1, 16, 3);                    // p = 65537
      add_cand(5, 3, 3);                     // p = 41
      add_cand(7, 2, 5);                     // p = 29 prime, verdict depends on a
      add_cand(3, 3, 2);                     // p = 25 composite
      add_cand(0, 5, 3);                     // zero multiplier
      add_cand(5, 0, 3);                     // zero exponent
      add_cand(1, 1, 0);                     // base zero
      add_cand(1, 2, 10);                    // base multiple of p
      add_cand(1, 16, 16'hFFFF);             // base all ones
      add_cand(6, 3, 7);                     // even multiplier
      add_cand(32'h8000_0001, 1, 16'h5A5A);  // 33-bit candidate
      add_cand(32'hFFFF_FFFF, 32, 16'hA5A5); // 64-bit candidate
      add_cand(32'hFFFF_FFFF, 1023, 3);      // oversized, every bit high
      add_cand(32'h8000_0000, 1000, 3);      // oversized, even k
      add_cand(32'h7FFF_FFFF, 1, 1);
      drain();

      // random phases with different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 57) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 57) : 0;
         for (int i = 0; i < 25; i++) add_random_cand();
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("PASS proth_primality_test");
      else
         $display("FAIL proth_primality_test");
      $finish;
   end

endmodule
